[design/stvf_pkg.sv]
package stvf_pkg;

  // Operation codes carried by each input transaction.
  typedef enum logic [2:0] {
    OP_REFRESH = 3'd0,
    OP_ENABLE  = 3'd1,
    OP_DISABLE = 3'd2,
    OP_STOP    = 3'd3,
    OP_VOLUME  = 3'd4
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_SLEEP_DURATION = 2'd0,
    CFG_TIMER_FADE     = 2'd1,
    CFG_STOP_FADE      = 2'd2
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CHECK,
    ST_ELAPSED,
    ST_COMPARE,
    ST_MULTIPLY,
    ST_DIVIDE,
    ST_FINISH,
    ST_DONE
  } ctrl_state_e;

  // Datapath operation selected by the controller in each cycle.
  typedef enum logic [2:0] {
    DP_NONE,
    DP_EXEC,
    DP_CHECK,
    DP_ELAPSED,
    DP_COMPARE,
    DP_MULTIPLY,
    DP_DIVIDE,
    DP_FINISH
  } dp_cmd_e;

  localparam int unsigned FadeWidth   = 26;
  localparam int unsigned SleepWidth  = 32;
  localparam int unsigned TimeWidth   = 64;
  localparam int unsigned VolWidth    = 7;
  localparam int unsigned ProdWidth   = FadeWidth + VolWidth;
  localparam int unsigned QuotBits    = 7;
  localparam int unsigned StepWidth   = 3;

  localparam logic [VolWidth-1:0]   VolumeMax        = 7'd100;
  localparam logic [VolWidth-1:0]   VolumeReset      = 7'd40;
  localparam logic [SleepWidth-1:0] SleepReset       = 32'd1800000000;
  localparam logic [FadeWidth-1:0]  TimerFadeReset   = 26'd15000000;
  localparam logic [FadeWidth-1:0]  StopFadeReset    = 26'd500000;
  localparam logic [StepWidth-1:0]  DivFirstStep     = 3'(QuotBits - 1);

  typedef struct packed {
    logic    load_in;
    dp_cmd_e op_cmd;
    logic    load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_refresh;
    logic play_on;
    logic fade_on;
    logic timer_expired;
    logic fade_ends;
    logic div_last;
  } dp_status_t;

endpackage

[design/stvf_ctrl.sv]
module stvf_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  stvf_pkg::dp_status_t status_i,
  output stvf_pkg::ctrl_cmd_t  cmd_o
);
  import stvf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d        = state_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.op_cmd   = DP_NONE;
    cmd_o.load_out = 1'b0;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.op_cmd = DP_EXEC;
        state_d = (status_i.is_refresh && status_i.play_on) ? ST_CHECK : ST_DONE;
      end
      ST_CHECK: begin
        cmd_o.op_cmd = DP_CHECK;
        state_d = (status_i.fade_on || status_i.timer_expired) ? ST_ELAPSED : ST_DONE;
      end
      ST_ELAPSED: begin
        cmd_o.op_cmd = DP_ELAPSED;
        state_d      = ST_COMPARE;
      end
      ST_COMPARE: begin
        cmd_o.op_cmd = DP_COMPARE;
        state_d = status_i.fade_ends ? ST_DONE : ST_MULTIPLY;
      end
      ST_MULTIPLY: begin
        cmd_o.op_cmd = DP_MULTIPLY;
        state_d      = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd_o.op_cmd = DP_DIVIDE;
        if (status_i.div_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd_o.op_cmd = DP_FINISH;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register holds a result until its transaction completes.
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[design/stvf_datapath.sv]
module stvf_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  logic [2:0]           op_i,
  input  logic [63:0]          now_us_i,
  input  logic [7:0]           volume_value_i,
  input  stvf_pkg::ctrl_cmd_t  cmd_i,
  output stvf_pkg::dp_status_t status_o,
  output logic                 playing_o,
  output logic [6:0]           effective_volume_o,
  output logic                 fading_o
);
  import stvf_pkg::*;

  // Latched input transaction.
  op_e                   op_q;
  logic [TimeWidth-1:0]  now_q;
  logic [7:0]            vol_q;

  // Configuration registers.
  logic [SleepWidth-1:0] sleep_dur_q;
  logic [FadeWidth-1:0]  timer_fade_q;
  logic [FadeWidth-1:0]  stop_fade_q;

  // Block state.
  logic                  play_on_q, play_on_d;
  logic [VolWidth-1:0]   user_vol_q, user_vol_d;
  logic [VolWidth-1:0]   scaled_vol_q, scaled_vol_d;
  logic [TimeWidth-1:0]  deadline_q, deadline_d;
  logic [TimeWidth-1:0]  fade_start_q, fade_start_d;
  logic [FadeWidth-1:0]  fade_len_q, fade_len_d;
  logic                  fade_on_q, fade_on_d;

  // Fade arithmetic work registers.
  logic [TimeWidth-1:0]  elapsed_q, elapsed_d;
  logic [FadeWidth-1:0]  remaining_q, remaining_d;
  logic [ProdWidth-1:0]  rem_q, rem_d;
  logic [QuotBits-1:0]   quot_q, quot_d;
  logic [StepWidth-1:0]  cnt_q, cnt_d;

  // Result register payload.
  logic                  playing_q;
  logic [VolWidth-1:0]   eff_vol_q;
  logic                  fading_q;

  logic                  timer_expired;
  logic                  fade_ends;
  logic [ProdWidth-1:0]  div_shifted;
  logic [VolWidth-1:0]   vol_clamped;

  // Input capture, work registers and result payload; these need no reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= op_e'(op_i);
      now_q <= now_us_i;
      vol_q <= volume_value_i;
    end
    if (cmd_i.load_out) begin
      playing_q <= play_on_q;
      eff_vol_q <= scaled_vol_q;
      fading_q  <= fade_on_q;
    end
    elapsed_q   <= elapsed_d;
    remaining_q <= remaining_d;
    rem_q       <= rem_d;
    quot_q      <= quot_d;
    cnt_q       <= cnt_d;
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sleep_dur_q  <= SleepReset;
      timer_fade_q <= TimerFadeReset;
      stop_fade_q  <= StopFadeReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_SLEEP_DURATION: sleep_dur_q  <= cfg_data_i;
        CFG_TIMER_FADE:     timer_fade_q <= cfg_data_i[FadeWidth-1:0];
        CFG_STOP_FADE:      stop_fade_q  <= cfg_data_i[FadeWidth-1:0];
        default: ;
      endcase
    end
  end

  // Block state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      play_on_q    <= 1'b0;
      user_vol_q   <= VolumeReset;
      scaled_vol_q <= VolumeReset;
      deadline_q   <= '0;
      fade_start_q <= '0;
      fade_len_q   <= '0;
      fade_on_q    <= 1'b0;
    end else begin
      play_on_q    <= play_on_d;
      user_vol_q   <= user_vol_d;
      scaled_vol_q <= scaled_vol_d;
      deadline_q   <= deadline_d;
      fade_start_q <= fade_start_d;
      fade_len_q   <= fade_len_d;
      fade_on_q    <= fade_on_d;
    end
  end

  // Status toward the controller.
  assign timer_expired = (deadline_q != '0) && (now_q >= deadline_q);
  assign fade_ends = (fade_len_q == '0) || (elapsed_q[TimeWidth-1:FadeWidth] != '0) ||
                     (elapsed_q[FadeWidth-1:0] >= fade_len_q);
  assign div_shifted = {{VolWidth{1'b0}}, fade_len_q} << cnt_q;
  assign vol_clamped = (vol_q > {1'b0, VolumeMax}) ? VolumeMax : vol_q[VolWidth-1:0];

  assign status_o.is_refresh    = (op_q == OP_REFRESH);
  assign status_o.play_on       = play_on_q;
  assign status_o.fade_on       = fade_on_q;
  assign status_o.timer_expired = timer_expired;
  assign status_o.fade_ends     = fade_ends;
  assign status_o.div_last      = (cnt_q == '0);

  // State updates for each datapath operation.
  always_comb begin
    play_on_d    = play_on_q;
    user_vol_d   = user_vol_q;
    scaled_vol_d = scaled_vol_q;
    deadline_d   = deadline_q;
    fade_start_d = fade_start_q;
    fade_len_d   = fade_len_q;
    fade_on_d    = fade_on_q;
    elapsed_d    = elapsed_q;
    remaining_d  = remaining_q;
    rem_d        = rem_q;
    quot_d       = quot_q;
    cnt_d        = cnt_q;
    case (cmd_i.op_cmd)
      DP_EXEC: begin
        case (op_q)
          OP_REFRESH: begin
            if (!play_on_q) begin
              scaled_vol_d = user_vol_q;
            end
          end
          OP_ENABLE: begin
            play_on_d    = 1'b1;
            deadline_d   = now_q + {{(TimeWidth-SleepWidth){1'b0}}, sleep_dur_q};
            fade_on_d    = 1'b0;
            fade_start_d = '0;
            fade_len_d   = '0;
            scaled_vol_d = user_vol_q;
          end
          OP_DISABLE: begin
            play_on_d    = 1'b0;
            deadline_d   = '0;
            fade_on_d    = 1'b0;
            fade_start_d = '0;
            fade_len_d   = '0;
            scaled_vol_d = user_vol_q;
          end
          OP_STOP: begin
            if (play_on_q && !fade_on_q) begin
              fade_on_d    = 1'b1;
              fade_start_d = now_q;
              fade_len_d   = stop_fade_q;
            end
          end
          OP_VOLUME: begin
            user_vol_d = vol_clamped;
          end
          default: ;
        endcase
      end
      DP_CHECK: begin
        // Start the long fade once the deadline has passed.
        if (!fade_on_q) begin
          if (timer_expired) begin
            fade_on_d    = 1'b1;
            fade_start_d = now_q;
            fade_len_d   = timer_fade_q;
          end else begin
            scaled_vol_d = user_vol_q;
          end
        end
      end
      DP_ELAPSED: begin
        elapsed_d = now_q - fade_start_q;
      end
      DP_COMPARE: begin
        if (fade_ends) begin
          scaled_vol_d = '0;
          play_on_d    = 1'b0;
          fade_on_d    = 1'b0;
          deadline_d   = '0;
        end else begin
          remaining_d = fade_len_q - elapsed_q[FadeWidth-1:0];
        end
      end
      DP_MULTIPLY: begin
        rem_d  = {{FadeWidth{1'b0}}, user_vol_q} * {{VolWidth{1'b0}}, remaining_q};
        quot_d = '0;
        cnt_d  = DivFirstStep;
      end
      DP_DIVIDE: begin
        // One restoring division step per cycle, most significant bit first.
        if (rem_q >= div_shifted) begin
          rem_d          = rem_q - div_shifted;
          quot_d[cnt_q]  = 1'b1;
        end
        cnt_d = cnt_q - StepWidth'(1);
      end
      DP_FINISH: begin
        scaled_vol_d = quot_q;
      end
      default: ;
    endcase
  end

  assign playing_o          = playing_q;
  assign effective_volume_o = eff_vol_q;
  assign fading_o           = fading_q;

endmodule

[design/sleep_timer_volume_fader.sv]
// Channel   | Direction | Handshake               | Payload
// ----------+-----------+-------------------------+------------------------------------
// input     | in        | in_valid_i / in_ready_o | op_i, now_us_i, volume_value_i
// result    | out       | out_valid_o/out_ready_i | playing_o, effective_volume_o, fading_o
// config    | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// Each transaction yields one result, loaded in ST_DONE; a refresh while playing adds ST_CHECK,
// and a fade runs ST_ELAPSED to ST_FINISH via the divider; no new input until it is loaded.
// Reset is asynchronous and active low; it clears control, state and configuration
// registers, while input capture, work and payload registers need no reset.
// A stalled result register holds the finished transaction; the next input is accepted
// meanwhile, and its result waits in ST_DONE until the register is free.
module sleep_timer_volume_fader (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [63:0] now_us_i,
  input  logic [7:0]  volume_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        playing_o,
  output logic [6:0]  effective_volume_o,
  output logic        fading_o
);
  import stvf_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  stvf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  stvf_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .op_i               (op_i),
    .now_us_i           (now_us_i),
    .volume_value_i     (volume_value_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .playing_o          (playing_o),
    .effective_volume_o (effective_volume_o),
    .fading_o           (fading_o)
  );

endmodule

[design/stvf_checker.sv]
module stvf_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       playing_o,
  input logic [6:0] effective_volume_o,
  input logic       fading_o
);

  // A stalled result keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(playing_o) &&
      $stable(effective_volume_o) && $stable(fading_o))
    else $error("stalled result changed");

  // The volume never exceeds the clamp limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> effective_volume_o <= 7'd100)
    else $error("effective volume above 100");

  // A fade only runs while playback is on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fading_o |-> playing_o)
    else $error("fading reported while not playing");

  // One transaction at a time: the block is busy right after an acceptance.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while busy");

endmodule

bind sleep_timer_volume_fader stvf_checker u_stvf_checker (.*);

[sim/tb_sleep_timer_volume_fader.sv]
module tb_sleep_timer_volume_fader;
  timeunit 1ns;
  timeprecision 1ps;

  import stvf_pkg::*;

  // Opcodes and register index that the block must treat as no-ops.
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam logic [1:0] CFG_SPARE  = 2'd3;

  localparam logic [6:0]  VOL_CEIL        = 7'd100;
  localparam int          NUM_ROWS        = 26;
  localparam int          NUM_PHASES      = 8;
  localparam int          ITEMS_PER_PHASE = 172;
  localparam int          DRAIN_CYCLES    = 32;

  typedef struct packed {
    logic       playing;
    logic [6:0] level;
    logic       fading;
  } fader_status_t;

  typedef struct {
    logic [2:0]    op;
    logic [63:0]   now;
    logic [7:0]    vol;
    bit            fixed;
    fader_status_t want;
  } fader_row_t;

  // DUT connections; the inputs are known from time zero.
  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        cfg_we_i       = 1'b0;
  logic [1:0]  cfg_index_i    = 2'd0;
  logic [31:0] cfg_data_i     = 32'd0;
  logic        in_valid_i     = 1'b0;
  logic        in_ready_o;
  logic [2:0]  op_i           = 3'd0;
  logic [63:0] now_us_i       = 64'd0;
  logic [7:0]  volume_value_i = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i    = 1'b0;
  logic        playing_o;
  logic [6:0]  effective_volume_o;
  logic        fading_o;

  // Register copies used by the predictor, at their reset values.
  logic [31:0] sleep_us      = 32'd1800000000;
  logic [25:0] timer_fade_us = 26'd15000000;
  logic [25:0] stop_fade_us  = 26'd500000;

  // Predicted fader state.
  logic        fdr_playing  = 1'b0;
  logic [6:0]  fdr_user_vol = 7'd40;
  logic [6:0]  fdr_level    = 7'd40;
  logic [63:0] fdr_deadline = 64'd0;
  logic [63:0] fdr_fade_t0  = 64'd0;
  logic [25:0] fdr_fade_len = 26'd0;
  logic        fdr_fading   = 1'b0;

  fader_status_t fader_status_q[$];
  int            mismatches = 0;
  int            idle_max   = 18;
  fader_row_t    directed_rows [0:NUM_ROWS-1];

  sleep_timer_volume_fader uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .op_i               (op_i),
    .now_us_i           (now_us_i),
    .volume_value_i     (volume_value_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .playing_o          (playing_o),
    .effective_volume_o (effective_volume_o),
    .fading_o           (fading_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // A fade starts only while playing and not already fading.
  function automatic void open_fade(logic [63:0] now, logic [25:0] len);
    if (fdr_playing && !fdr_fading) begin
      fdr_fading   = 1'b1;
      fdr_fade_t0  = now;
      fdr_fade_len = len;
    end
  endfunction

  function automatic void drop_fade();
    fdr_fading   = 1'b0;
    fdr_fade_t0  = 64'd0;
    fdr_fade_len = 26'd0;
    fdr_level    = fdr_user_vol;
  endfunction

  // Apply one operation to the predicted state and report the status after it.
  task automatic advance_fader(input logic [2:0] op, input logic [63:0] now,
                               input logic [7:0] vol, output fader_status_t st);
    logic [63:0] elapsed;
    logic [63:0] remaining;
    case (op)
      OP_REFRESH: begin
        if (!fdr_playing) begin
          fdr_level = fdr_user_vol;
        end else begin
          // A passed deadline kicks off the long fade.
          if (!fdr_fading && fdr_deadline != 64'd0 && now >= fdr_deadline)
            open_fade(now, timer_fade_us);
          if (!fdr_fading) begin
            fdr_level = fdr_user_vol;
          end else begin
            // Elapsed time wraps, so a timestamp before the fade start ends it.
            elapsed = now - fdr_fade_t0;
            if (fdr_fade_len == 26'd0 || elapsed >= 64'(fdr_fade_len)) begin
              fdr_level    = 7'd0;
              fdr_playing  = 1'b0;
              fdr_fading   = 1'b0;
              fdr_deadline = 64'd0;
            end else begin
              remaining = 64'(fdr_fade_len) - elapsed;
              fdr_level = 7'((64'(fdr_user_vol) * remaining) / 64'(fdr_fade_len));
            end
          end
        end
      end
      OP_ENABLE: begin
        fdr_playing  = 1'b1;
        fdr_deadline = now + 64'(sleep_us);
        drop_fade();
      end
      OP_DISABLE: begin
        fdr_playing  = 1'b0;
        fdr_deadline = 64'd0;
        drop_fade();
      end
      OP_STOP: begin
        open_fade(now, stop_fade_us);
      end
      OP_VOLUME: begin
        fdr_user_vol = (vol > 8'(VOL_CEIL)) ? VOL_CEIL : vol[6:0];
      end
      default: begin
      end
    endcase
    st = '{fdr_playing, fdr_level, fdr_fading};
  endtask

  // Present one transaction after a random gap and queue its status once accepted.
  task automatic send_op(input logic [2:0] op, input logic [63:0] now,
                         input logic [7:0] vol, input bit fixed,
                         input fader_status_t fixed_status);
    int unsigned   gap;
    fader_status_t st;
    gap = $urandom_range(0, idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    now_us_i       <= now;
    volume_value_i <= vol;
    do @(posedge clk_i); while (!in_ready_o);
    advance_fader(op, now, vol, st);
    fader_status_q.push_back(fixed ? fixed_status : st);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      CFG_SLEEP_DURATION: sleep_us = data;
      CFG_TIMER_FADE:     timer_fade_us = data[25:0];
      CFG_STOP_FADE:      stop_fade_us = data[25:0];
      default: begin
      end
    endcase
  endtask

  // Directed transactions under the reset register values.
  initial begin
    directed_rows = '{
      '{OP_REFRESH, 64'd0,                   8'd0,   1'b1, '{1'b0, 7'd40,  1'b0}},
      '{OP_VOLUME,  64'd0,                   8'd255, 1'b1, '{1'b0, 7'd40,  1'b0}},
      '{OP_REFRESH, 64'd5,                   8'd0,   1'b1, '{1'b0, 7'd100, 1'b0}},
      '{OP_VOLUME,  64'd6,                   8'd0,   1'b1, '{1'b0, 7'd100, 1'b0}},
      '{OP_VOLUME,  64'd7,                   8'd100, 1'b1, '{1'b0, 7'd100, 1'b0}},
      '{OP_STOP,    64'd10,                  8'd0,   1'b1, '{1'b0, 7'd100, 1'b0}},
      '{OP_ENABLE,  64'd1000,                8'd0,   1'b1, '{1'b1, 7'd100, 1'b0}},
      '{OP_REFRESH, 64'd2000,                8'd0,   1'b1, '{1'b1, 7'd100, 1'b0}},
      '{OP_REFRESH, 64'd1800001000,          8'd0,   1'b1, '{1'b1, 7'd100, 1'b1}},
      '{OP_STOP,    64'd1800001001,          8'd0,   1'b1, '{1'b1, 7'd100, 1'b1}},
      '{OP_REFRESH, 64'd1807501000,          8'd0,   1'b0, '0},
      '{OP_REFRESH, 64'd1800000999,          8'd0,   1'b1, '{1'b0, 7'd0,   1'b0}},
      '{OP_ENABLE,  64'hFFFF_FFFF_94B6_2E00, 8'd0,   1'b1, '{1'b1, 7'd100, 1'b0}},
      '{OP_REFRESH, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0,   1'b1, '{1'b1, 7'd100, 1'b0}},
      '{OP_STOP,    64'd100,                 8'd0,   1'b1, '{1'b1, 7'd100, 1'b1}},
      '{OP_REFRESH, 64'd101,                 8'd0,   1'b0, '0},
      '{OP_REFRESH, 64'd500100,              8'd0,   1'b1, '{1'b0, 7'd0,   1'b0}},
      '{OP_SPARE_5, 64'd600000,              8'd0,   1'b1, '{1'b0, 7'd0,   1'b0}},
      '{OP_ENABLE,  64'hFFFF_FFFF_FFFF_FFFF, 8'd0,   1'b0, '0},
      '{OP_REFRESH, 64'd0,                   8'd0,   1'b0, '0},
      '{OP_REFRESH, 64'd1799999999,          8'd0,   1'b0, '0},
      '{OP_REFRESH, 64'd1814999998,          8'd0,   1'b0, '0},
      '{OP_SPARE_7, 64'd0,                   8'hAA,  1'b0, '0},
      '{OP_VOLUME,  64'd0,                   8'd57,  1'b0, '0},
      '{OP_DISABLE, 64'd0,                   8'd0,   1'b1, '{1'b0, 7'd57,  1'b0}},
      '{OP_SPARE_6, 64'd0,                   8'd0,   1'b0, '0}
    };
  end

  // Stimulus: directed rows, then random phases under changing registers.
  initial begin : stimulus
    int          phase;
    int          n;
    int unsigned pick;
    logic [31:0] sleep_w;
    logic [31:0] timer_w;
    logic [31:0] stop_w;
    logic [63:0] now_cur;
    logic [63:0] step;
    logic [63:0] t;
    logic [2:0]  op;
    logic [7:0]  vol;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i])
      send_op(directed_rows[i].op, directed_rows[i].now, directed_rows[i].vol,
              directed_rows[i].fixed, directed_rows[i].want);
    in_valid_i <= 1'b0;
    now_cur = 64'd0;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // Registers change only with nothing in flight.
      while (fader_status_q.size() != 0) @(posedge clk_i);
      case (phase)
        0: begin
          sleep_w = 32'd1;
          timer_w = 32'd0;
          stop_w  = 32'd0;
        end
        1: begin
          sleep_w = 32'd4000000000;
          timer_w = 32'd40000000;
          stop_w  = 32'd40000000;
        end
        2: begin
          // Upper bits of the fade registers are dropped by the 26-bit width.
          sleep_w = 32'hFFFF_FFFF;
          timer_w = 32'hFFFF_FFFF;
          stop_w  = 32'hFC00_0001;
        end
        default: begin
          sleep_w = $urandom_range(1, 3000000);
          timer_w = $urandom_range(0, 2000000);
          if ($urandom_range(0, 3) == 0)
            timer_w[31:26] = 6'($urandom);
          stop_w = ($urandom_range(0, 5) == 0) ? 32'd0 : $urandom_range(0, 400000);
        end
      endcase
      idle_max = (phase == 1 || phase == 5) ? 0 : 18;
      write_reg(CFG_SLEEP_DURATION, sleep_w);
      write_reg(CFG_TIMER_FADE, timer_w);
      write_reg(CFG_STOP_FADE, stop_w);
      if (phase == 2)
        write_reg(CFG_SPARE, $urandom);
      cfg_we_i <= 1'b0;

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Time moves forward on the scale of a stop fade, a timer fade or the sleep.
        case ($urandom_range(0, 3))
          0:       step = $urandom_range(0, 3);
          1:       step = $urandom_range(0, stop_fade_us / 3 + 1);
          2:       step = $urandom_range(0, timer_fade_us / 3 + 1);
          default: step = $urandom_range(0, sleep_us / 3 + 1);
        endcase
        now_cur = now_cur + step;
        t       = now_cur;
        vol     = $urandom_range(0, 255);
        pick    = $urandom_range(0, 99);
        if (pick < 50) begin
          op = OP_REFRESH;
        end else if (pick < 60) begin
          op = OP_ENABLE;
        end else if (pick < 64) begin
          op = OP_DISABLE;
        end else if (pick < 76) begin
          op = OP_STOP;
        end else if (pick < 88) begin
          op = OP_VOLUME;
        end else if (pick < 92) begin
          case ($urandom_range(0, 2))
            0:       op = OP_SPARE_5;
            1:       op = OP_SPARE_6;
            default: op = OP_SPARE_7;
          endcase
        end else begin
          // Noise: a jump anywhere in the 64-bit range, or a step back in time.
          op = OP_REFRESH;
          if ($urandom_range(0, 1) == 1) begin
            now_cur = {$urandom, $urandom};
            t       = now_cur;
          end else begin
            t = now_cur - 64'($urandom_range(1, 5000));
          end
        end
        send_op(op, t, vol, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    while (fader_status_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("sleep_timer_volume_fader verification clean");
    else
      $display("sleep_timer_volume_fader verification failed");
    $finish;
  end

  // Result side: random stalls drawn per transaction.
  initial begin : result_sink
    int unsigned hold;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = $urandom_range(0, idle_max);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // Compare every accepted result with the oldest queued status.
  always @(posedge clk_i) begin : check_results
    fader_status_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (fader_status_q.size() == 0) begin
        mismatches++;
        $display("%0t: result transaction with nothing outstanding", $time);
      end else begin
        want = fader_status_q.pop_front();
        if (playing_o !== want.playing) begin
          mismatches++;
          $display("%0t: playing expected %0d actual %0d", $time, want.playing, playing_o);
        end
        if (effective_volume_o !== want.level) begin
          mismatches++;
          $display("%0t: effective_volume expected %0d actual %0d", $time, want.level,
                   effective_volume_o);
        end
        if (fading_o !== want.fading) begin
          mismatches++;
          $display("%0t: fading expected %0d actual %0d", $time, want.fading, fading_o);
        end
      end
    end
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #10_000_000;
    $display("sleep_timer_volume_fader verification failed");
    $finish;
  end

endmodule

[files.f]
design/stvf_pkg.sv
design/stvf_ctrl.sv
design/stvf_datapath.sv
design/sleep_timer_volume_fader.sv
design/stvf_checker.sv
sim/tb_sleep_timer_volume_fader.sv
